// ----- rtl/i2c_bus_bridge_access_sequencer_assert.svh -----
// assertion macros shared by the checker
`ifndef I2C_BUS_BRIDGE_ACCESS_SEQUENCER_ASSERT_SVH
`define I2C_BUS_BRIDGE_ACCESS_SEQUENCER_ASSERT_SVH
// checked only out of reset
`define BBAS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("bbas check failed");
// checked in reset as well
`define BBAS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) else $error("bbas check failed");
`endif

// ----- rtl/bbas_pkg.sv -----
package bbas_pkg;

  localparam logic [2:0] CMD_RD_WORD = 3'd0;
  localparam logic [2:0] CMD_WR_WORD = 3'd1;
  localparam logic [2:0] CMD_RD_BYTE = 3'd2;
  localparam logic [2:0] CMD_WR_BYTE = 3'd3;
  localparam logic [2:0] CMD_BURST_RD = 3'd4;
  localparam logic [2:0] CMD_BURST_WR = 3'd5;
  localparam logic [2:0] CMD_LOAD = 3'd6;
  localparam logic [2:0] CMD_RESP = 3'd7;

  localparam logic [1:0] KIND_ISSUE = 2'd0;
  localparam logic [1:0] KIND_BYTE = 2'd1;
  localparam logic [1:0] KIND_FINISH = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FAIL = 2'd1;
  localparam logic [1:0] ST_TIMEOUT = 2'd2;

  localparam logic [1:0] REG_SLAVE = 2'd0;
  localparam logic [1:0] REG_POLL_LIMIT = 2'd1;
  localparam logic [1:0] REG_ATTEMPTS = 2'd2;

  localparam logic [5:0] SUB_ADDR = 6'h00;
  localparam logic [5:0] SUB_WDATA = 6'h04;
  localparam logic [5:0] SUB_RDATA = 6'h08;
  localparam logic [5:0] SUB_CMD = 6'h0C;
  localparam logic [5:0] SUB_DLEN = 6'h10;
  localparam logic [5:0] SUB_DRST = 6'h20;
  localparam logic [5:0] SUB_BWPORT = 6'h21;
  localparam logic [5:0] SUB_BRPORT = 6'h22;

  localparam logic [7:0] OP_READ = 8'h02;
  localparam logic [7:0] OP_WRITE = 8'h01;
  localparam logic [7:0] OP_BURST_RD = 8'h08;
  localparam logic [7:0] OP_BURST_WR = 8'h04;

  localparam logic [10:0] POLL_LIMIT_RST = 11'd1500;
  localparam logic [10:0] POLL_SAT = 11'd2047;
  localparam logic [3:0] ATTEMPTS_RST = 4'd4;
  localparam logic [3:0] ATTEMPTS_MAX = 4'd8;
  localparam logic [8:0] BURST_MAX = 9'd256;

  localparam logic [4:0] PH_IDLE = 5'd0;
  localparam logic [4:0] PH_SEL = 5'd1;
  localparam logic [4:0] PH_WDATA = 5'd2;
  localparam logic [4:0] PH_RDCMD = 5'd3;
  localparam logic [4:0] PH_RDPOLL = 5'd4;
  localparam logic [4:0] PH_RDATA = 5'd5;
  localparam logic [4:0] PH_SEL2 = 5'd6;
  localparam logic [4:0] PH_WRCMD = 5'd7;
  localparam logic [4:0] PH_WRPOLL = 5'd8;
  localparam logic [4:0] PH_DLEN = 5'd9;
  localparam logic [4:0] PH_RST1 = 5'd10;
  localparam logic [4:0] PH_TRIG = 5'd11;
  localparam logic [4:0] PH_TPOLL = 5'd12;
  localparam logic [4:0] PH_TREAD = 5'd13;
  localparam logic [4:0] PH_RST2 = 5'd14;
  localparam logic [4:0] PH_BRDATA = 5'd15;
  localparam logic [4:0] PH_BWDATA = 5'd16;

  typedef struct packed {
    logic [1:0]  kind;
    logic        txn_is_read;
    logic [5:0]  sub_address;
    logic [7:0]  txn_data;
    logic [31:0] read_value;
    logic [1:0]  status;
    logic [8:0]  transferred;
    logic        last;
  } res_t;

  // results of one request, waiting for the buffer read data
  typedef struct packed {
    logic [1:0] num;
    logic       use_mem;
    logic       mem_zero;
    res_t       r0;
    res_t       r1;
  } stage_t;

endpackage

// ----- rtl/bbas_if.sv -----
interface bbas_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [31:0] address;
  logic [31:0] write_value;
  logic [8:0]  byte_count;
  logic [7:0]  buffer_index;
  logic        resp_ok;
  logic [7:0]  resp_data;
  modport source (output valid, cmd, address, write_value, byte_count, buffer_index,
                  resp_ok, resp_data, input ready);
  modport sink (input valid, cmd, address, write_value, byte_count, buffer_index,
                resp_ok, resp_data, output ready);
endinterface

interface bbas_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic        txn_is_read;
  logic [5:0]  sub_address;
  logic [7:0]  txn_data;
  logic [31:0] read_value;
  logic [1:0]  status;
  logic [8:0]  transferred;
  logic        last;
  modport source (output valid, kind, txn_is_read, sub_address, txn_data, read_value,
                  status, transferred, last, input ready);
  modport sink (input valid, kind, txn_is_read, sub_address, txn_data, read_value,
                status, transferred, last, output ready);
endinterface

interface bbas_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [10:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/i2c_bus_bridge_access_sequencer.sv -----
// the results of an accepted item are held in the stage register before they enter the result queue
// throughput: one item per cycle while the output side takes results; an item may give two
// results, and input is held back when the four-entry result queue could overflow
// burst bytes sit in a buffer ram with separate read and write ports; its read data is registered beside the stage
// reset: asynchronous, active low; sequencer idle, queue empty, registers at default values
module i2c_bus_bridge_access_sequencer #(
  parameter int BUFFER_DEPTH = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bbas_in_if.sink    in_s,
  bbas_out_if.source out_s,
  bbas_cfg_if.sink   cfg_s
);

  localparam int Aw = $clog2(BUFFER_DEPTH);

  logic [6:0]  slave_address_q;
  logic [10:0] poll_limit_q;
  logic [3:0]  max_attempts_q;
  logic        in_acc;
  logic        mem_we;
  logic [Aw-1:0] mem_waddr, mem_raddr;
  logic [7:0]  mem_rdata;
  logic [2:0]  q_count;
  logic [2:0]  inflight;
  bbas_pkg::stage_t stage;
  bbas_pkg::res_t   push0, q_data;

  assign cfg_s.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_address_q <= '0;
      poll_limit_q <= bbas_pkg::POLL_LIMIT_RST;
      max_attempts_q <= bbas_pkg::ATTEMPTS_RST;
    end else if (cfg_s.valid) begin
      case (cfg_s.index)
        bbas_pkg::REG_SLAVE:      slave_address_q <= cfg_s.data[6:0];
        bbas_pkg::REG_POLL_LIMIT: poll_limit_q <= cfg_s.data;
        bbas_pkg::REG_ATTEMPTS:   max_attempts_q <= cfg_s.data[3:0];
        default: slave_address_q <= slave_address_q;
      endcase
    end
  end

  // room for two more results beyond what is queued and in flight
  assign inflight = {1'b0, stage.num};
  assign in_s.ready = (q_count + inflight) <= 3'd2;
  assign in_acc = in_s.valid && in_s.ready;

  bbas_seq #(.Depth(BUFFER_DEPTH), .Aw(Aw)) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (in_acc),
    .cmd_i          (in_s.cmd),
    .address_i      (in_s.address),
    .write_value_i  (in_s.write_value),
    .byte_count_i   (in_s.byte_count),
    .buffer_index_i (in_s.buffer_index),
    .resp_ok_i      (in_s.resp_ok),
    .resp_data_i    (in_s.resp_data),
    .poll_limit_i   (poll_limit_q),
    .max_attempts_i (max_attempts_q),
    .mem_we_o       (mem_we),
    .mem_waddr_o    (mem_waddr),
    .mem_raddr_o    (mem_raddr),
    .stage_o        (stage)
  );

  bbas_buf #(.Depth(BUFFER_DEPTH), .Aw(Aw)) u_buf (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (in_s.write_value[7:0]),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    push0 = stage.r0;
    if (stage.use_mem) begin
      push0.txn_data = stage.mem_zero ? 8'd0 : mem_rdata;
    end
  end

  bbas_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_num_i (stage.num),
    .push0_i    (push0),
    .push1_i    (stage.r1),
    .pop_i      (out_s.ready),
    .valid_o    (out_s.valid),
    .data_o     (q_data),
    .count_o    (q_count)
  );

  assign out_s.kind = q_data.kind;
  assign out_s.txn_is_read = q_data.txn_is_read;
  assign out_s.sub_address = q_data.sub_address;
  assign out_s.txn_data = q_data.txn_data;
  assign out_s.read_value = q_data.read_value;
  assign out_s.status = q_data.status;
  assign out_s.transferred = q_data.transferred;
  assign out_s.last = q_data.last;

endmodule

// ----- rtl/bbas_buf.sv -----
module bbas_buf #(
  parameter int Depth = 256,
  parameter int Aw = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [Aw-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic [Aw-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/bbas_outq.sv -----
module bbas_outq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [1:0]          push_num_i,
  input  bbas_pkg::res_t      push0_i,
  input  bbas_pkg::res_t      push1_i,
  input  logic                pop_i,
  output logic                valid_o,
  output bbas_pkg::res_t      data_o,
  output logic [2:0]          count_o
);

  bbas_pkg::res_t slot_q [4];
  logic [1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [2:0] cnt_q, cnt_d;
  logic       do_pop;

  assign do_pop = pop_i && (cnt_q != 3'd0);

  always_comb begin
    wptr_d = wptr_q + push_num_i;
    rptr_d = rptr_q + {1'b0, do_pop};
    cnt_d = cnt_q + {1'b0, push_num_i} - {2'b00, do_pop};
  end

  always_ff @(posedge clk_i) begin
    if (push_num_i != 2'd0) begin
      slot_q[wptr_q] <= push0_i;
    end
    if (push_num_i == 2'd2) begin
      slot_q[wptr_q + 2'd1] <= push1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q <= cnt_d;
    end
  end

  assign valid_o = cnt_q != 3'd0;
  assign data_o = slot_q[rptr_q];
  assign count_o = cnt_q;

endmodule

// ----- rtl/bbas_seq.sv -----
module bbas_seq #(
  parameter int Depth = 256,
  parameter int Aw = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [2:0]           cmd_i,
  input  logic [31:0]          address_i,
  input  logic [31:0]          write_value_i,
  input  logic [8:0]           byte_count_i,
  input  logic [7:0]           buffer_index_i,
  input  logic                 resp_ok_i,
  input  logic [7:0]           resp_data_i,
  input  logic [10:0]          poll_limit_i,
  input  logic [3:0]           max_attempts_i,
  output logic                 mem_we_o,
  output logic [Aw-1:0]        mem_waddr_o,
  output logic [Aw-1:0]        mem_raddr_o,
  output bbas_pkg::stage_t     stage_o
);

  logic [4:0]  ph_q, ph_d;
  logic [2:0]  rk_q, rk_d;
  logic [31:0] ta_q, ta_d, wd_q, wd_d;
  logic [1:0]  lane_q, lane_d;
  logic [2:0]  step_q, step_d, att_q, att_d;
  logic [10:0] poll_q, poll_d, lim;
  logic [8:0]  tot_q, tot_d, pos_q, pos_d;
  logic [3:0]  tries;
  logic        do_fin, two;
  logic [1:0]  fin_st;
  logic [4:0]  sh;
  bbas_pkg::res_t main_r, echo_r;
  bbas_pkg::stage_t st_d;

  function automatic bbas_pkg::res_t issue_f(input logic [4:0] ph, input logic [2:0] step,
                                             input logic [31:0] ta, input logic [31:0] wd,
                                             input logic [2:0] rk, input logic [8:0] tot);
    bbas_pkg::res_t r;
    logic [31:0] tmp;
    logic [8:0]  len;
    r = '0;
    r.kind = bbas_pkg::KIND_ISSUE;
    r.last = 1'b1;
    tmp = '0;
    len = tot - 9'd1;
    case (ph)
      bbas_pkg::PH_SEL, bbas_pkg::PH_SEL2: begin
        tmp = ta >> {step[1:0], 3'b000};
        r.sub_address = bbas_pkg::SUB_ADDR + {4'd0, step[1:0]};
        r.txn_data = tmp[7:0];
      end
      bbas_pkg::PH_WDATA: begin
        tmp = wd >> {step[1:0], 3'b000};
        r.sub_address = bbas_pkg::SUB_WDATA + {4'd0, step[1:0]};
        r.txn_data = tmp[7:0];
      end
      bbas_pkg::PH_RDCMD: begin
        r.sub_address = bbas_pkg::SUB_CMD;
        r.txn_data = bbas_pkg::OP_READ;
      end
      bbas_pkg::PH_WRCMD: begin
        r.sub_address = bbas_pkg::SUB_CMD;
        r.txn_data = bbas_pkg::OP_WRITE;
      end
      bbas_pkg::PH_TRIG: begin
        r.sub_address = bbas_pkg::SUB_CMD;
        r.txn_data = (rk == bbas_pkg::CMD_BURST_RD) ? bbas_pkg::OP_BURST_RD
                                                     : bbas_pkg::OP_BURST_WR;
      end
      bbas_pkg::PH_RDPOLL, bbas_pkg::PH_WRPOLL, bbas_pkg::PH_TPOLL,
      bbas_pkg::PH_TREAD: begin
        r.txn_is_read = 1'b1;
        r.sub_address = bbas_pkg::SUB_CMD;
      end
      bbas_pkg::PH_RDATA: begin
        r.txn_is_read = 1'b1;
        r.sub_address = bbas_pkg::SUB_RDATA + {4'd0, step[1:0]};
      end
      bbas_pkg::PH_DLEN: begin
        r.sub_address = bbas_pkg::SUB_DLEN;
        r.txn_data = len[7:0];
      end
      bbas_pkg::PH_RST1, bbas_pkg::PH_RST2: begin
        r.sub_address = bbas_pkg::SUB_DRST;
      end
      bbas_pkg::PH_BRDATA: begin
        r.txn_is_read = 1'b1;
        r.sub_address = bbas_pkg::SUB_BRPORT;
      end
      bbas_pkg::PH_BWDATA: begin
        // data byte is filled in from the buffer when the staged result is pushed
        r.sub_address = bbas_pkg::SUB_BWPORT;
      end
      default: begin
        r.sub_address = bbas_pkg::SUB_ADDR;
      end
    endcase
    return r;
  endfunction

  function automatic bbas_pkg::res_t finish_f(input logic [1:0] st, input logic [2:0] rk,
                                              input logic [31:0] wd, input logic [1:0] lane,
                                              input logic [8:0] pos);
    bbas_pkg::res_t r;
    logic [31:0] tmp;
    r = '0;
    tmp = wd >> {lane, 3'b000};
    r.kind = bbas_pkg::KIND_FINISH;
    r.status = st;
    r.last = 1'b1;
    if (st == bbas_pkg::ST_OK) begin
      if (rk == bbas_pkg::CMD_RD_WORD) begin
        r.read_value = wd;
      end else if (rk == bbas_pkg::CMD_RD_BYTE) begin
        r.read_value = {24'd0, tmp[7:0]};
      end
    end
    if (rk == bbas_pkg::CMD_BURST_RD || rk == bbas_pkg::CMD_BURST_WR) begin
      r.transferred = pos;
    end
    return r;
  endfunction

  always_comb begin
    lim = (poll_limit_i == 11'd0) ? 11'd1 : poll_limit_i;
    tries = (max_attempts_i == 4'd0) ? 4'd1 :
            ((max_attempts_i > bbas_pkg::ATTEMPTS_MAX) ? bbas_pkg::ATTEMPTS_MAX
                                                       : max_attempts_i);
    sh = {step_q[1:0], 3'b000};
    ph_d = ph_q; rk_d = rk_q; ta_d = ta_q; wd_d = wd_q; lane_d = lane_q;
    step_d = step_q; att_d = att_q; poll_d = poll_q; tot_d = tot_q; pos_d = pos_q;
    do_fin = 1'b0;
    fin_st = bbas_pkg::ST_OK;
    two = 1'b0;
    echo_r = '0;
    st_d = '0;
    mem_we_o = 1'b0;
    if (accept_i) begin
      st_d.num = 2'd1;
      if (cmd_i == bbas_pkg::CMD_LOAD) begin
        st_d.num = 2'd0;
        mem_we_o = {1'b0, buffer_index_i} < 9'(Depth);
      end else if (cmd_i == bbas_pkg::CMD_RESP) begin
        if (ph_q == bbas_pkg::PH_IDLE) begin
          st_d.num = 2'd0;
        end else if (!resp_ok_i) begin
          if ({1'b0, att_q} + 4'd1 >= tries) begin
            do_fin = 1'b1;
            fin_st = bbas_pkg::ST_FAIL;
          end else begin
            att_d = att_q + 3'd1;
          end
        end else begin
          att_d = '0;
          case (ph_q)
            bbas_pkg::PH_SEL, bbas_pkg::PH_SEL2, bbas_pkg::PH_WDATA: begin
              step_d = step_q + 3'd1;
              if (step_d == 3'd4) begin
                step_d = '0;
                if (ph_q == bbas_pkg::PH_WDATA) begin
                  ph_d = bbas_pkg::PH_WRCMD;
                end else if (ph_q == bbas_pkg::PH_SEL2 || rk_q == bbas_pkg::CMD_WR_WORD) begin
                  ph_d = bbas_pkg::PH_WDATA;
                end else if (rk_q[2]) begin
                  ph_d = bbas_pkg::PH_DLEN;
                end else begin
                  ph_d = bbas_pkg::PH_RDCMD;
                end
              end
            end
            bbas_pkg::PH_RDATA: begin
              // the lane being replaced by a byte write keeps its new value
              if (!(rk_q == bbas_pkg::CMD_WR_BYTE && step_q[1:0] == lane_q)) begin
                wd_d = (wd_q & ~(32'hFF << sh)) | ({24'd0, resp_data_i} << sh);
              end
              step_d = step_q + 3'd1;
              if (step_d == 3'd4) begin
                step_d = '0;
                if (rk_q == bbas_pkg::CMD_WR_BYTE) begin
                  ph_d = bbas_pkg::PH_SEL2;
                end else begin
                  do_fin = 1'b1;
                end
              end
            end
            bbas_pkg::PH_RDCMD: begin
              poll_d = '0;
              ph_d = bbas_pkg::PH_RDPOLL;
            end
            bbas_pkg::PH_WRCMD: begin
              poll_d = '0;
              ph_d = bbas_pkg::PH_WRPOLL;
            end
            bbas_pkg::PH_TRIG: begin
              poll_d = '0;
              ph_d = bbas_pkg::PH_TPOLL;
            end
            bbas_pkg::PH_RDPOLL, bbas_pkg::PH_WRPOLL, bbas_pkg::PH_TPOLL: begin
              if (poll_q < bbas_pkg::POLL_SAT) begin
                poll_d = poll_q + 11'd1;
              end
              if (resp_data_i == 8'd0) begin
                if (ph_q == bbas_pkg::PH_WRPOLL) begin
                  do_fin = 1'b1;
                end else begin
                  step_d = '0;
                  ph_d = (ph_q == bbas_pkg::PH_RDPOLL) ? bbas_pkg::PH_RDATA
                                                       : bbas_pkg::PH_TREAD;
                end
              end else if (poll_d >= lim) begin
                do_fin = 1'b1;
                fin_st = bbas_pkg::ST_TIMEOUT;
              end
            end
            bbas_pkg::PH_TREAD: begin
              if (rk_q == bbas_pkg::CMD_BURST_RD) begin
                ph_d = bbas_pkg::PH_RST2;
              end else begin
                do_fin = 1'b1;
              end
            end
            bbas_pkg::PH_DLEN: begin
              ph_d = bbas_pkg::PH_RST1;
            end
            bbas_pkg::PH_RST1: begin
              ph_d = (rk_q == bbas_pkg::CMD_BURST_RD) ? bbas_pkg::PH_TRIG
                                                      : bbas_pkg::PH_BWDATA;
            end
            bbas_pkg::PH_RST2: begin
              ph_d = (rk_q == bbas_pkg::CMD_BURST_RD) ? bbas_pkg::PH_BRDATA
                                                      : bbas_pkg::PH_TRIG;
            end
            bbas_pkg::PH_BRDATA: begin
              pos_d = pos_q + 9'd1;
              two = 1'b1;
              echo_r.kind = bbas_pkg::KIND_BYTE;
              echo_r.read_value = {24'd0, resp_data_i};
              echo_r.transferred = pos_d;
              if (pos_d >= tot_q) begin
                do_fin = 1'b1;
              end
            end
            bbas_pkg::PH_BWDATA: begin
              pos_d = pos_q + 9'd1;
              if (pos_d >= tot_q) begin
                ph_d = bbas_pkg::PH_RST2;
              end
            end
            default: begin
              ph_d = bbas_pkg::PH_IDLE;
              st_d.num = 2'd0;
            end
          endcase
        end
      end else if (ph_q == bbas_pkg::PH_IDLE) begin
        rk_d = cmd_i;
        lane_d = address_i[1:0];
        ta_d = (cmd_i == bbas_pkg::CMD_RD_BYTE || cmd_i == bbas_pkg::CMD_WR_BYTE)
               ? {address_i[31:2], 2'b00} : address_i;
        if (cmd_i == bbas_pkg::CMD_WR_WORD) begin
          wd_d = write_value_i;
        end else if (cmd_i == bbas_pkg::CMD_WR_BYTE) begin
          wd_d = {24'd0, write_value_i[7:0]} << {address_i[1:0], 3'b000};
        end else begin
          wd_d = '0;
        end
        tot_d = (byte_count_i == 9'd0) ? 9'd1 :
                ((byte_count_i > bbas_pkg::BURST_MAX) ? bbas_pkg::BURST_MAX : byte_count_i);
        pos_d = '0;
        step_d = '0;
        att_d = '0;
        poll_d = '0;
        ph_d = bbas_pkg::PH_SEL;
      end else begin
        st_d.num = 2'd0;
      end
    end
    if (do_fin) begin
      main_r = finish_f(fin_st, rk_q, wd_d, lane_q, pos_d);
      ph_d = bbas_pkg::PH_IDLE;
    end else begin
      main_r = issue_f(ph_d, step_d, ta_d, wd_d, rk_d, tot_d);
    end
    if (two) begin
      st_d.num = 2'd2;
      st_d.r0 = echo_r;
      st_d.r1 = main_r;
    end else begin
      st_d.r0 = main_r;
      st_d.use_mem = !do_fin && ph_d == bbas_pkg::PH_BWDATA;
    end
    st_d.mem_zero = pos_d >= 9'(Depth);
    mem_waddr_o = buffer_index_i[Aw-1:0];
    mem_raddr_o = pos_d[Aw-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= bbas_pkg::PH_IDLE;
      rk_q <= '0;
      ta_q <= '0;
      wd_q <= '0;
      lane_q <= '0;
      step_q <= '0;
      att_q <= '0;
      poll_q <= '0;
      tot_q <= '0;
      pos_q <= '0;
      stage_o <= '0;
    end else begin
      ph_q <= ph_d;
      rk_q <= rk_d;
      ta_q <= ta_d;
      wd_q <= wd_d;
      lane_q <= lane_d;
      step_q <= step_d;
      att_q <= att_d;
      poll_q <= poll_d;
      tot_q <= tot_d;
      pos_q <= pos_d;
      stage_o <= st_d;
    end
  end

endmodule

// ----- rtl/bbas_checker.sv -----
`include "i2c_bus_bridge_access_sequencer_assert.svh"

module bbas_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid,
  input logic [1:0]  out_kind,
  input logic        out_last,
  input logic [1:0]  out_status,
  input logic [31:0] out_read_value
);

  `BBAS_ASSERT_ALWAYS(a_no_result_in_reset, !rst_ni |-> !out_valid)
  `BBAS_ASSERT(a_finish_is_last, (out_valid && out_kind == bbas_pkg::KIND_FINISH) |-> out_last)
  `BBAS_ASSERT(a_byte_not_last, (out_valid && out_kind == bbas_pkg::KIND_BYTE) |-> !out_last)
  `BBAS_ASSERT(a_issue_clean, (out_valid && out_kind == bbas_pkg::KIND_ISSUE) |-> (out_last && out_status == bbas_pkg::ST_OK && out_read_value == 32'd0))

endmodule

bind i2c_bus_bridge_access_sequencer bbas_checker u_bbas_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid      (out_s.valid),
  .out_kind       (out_s.kind),
  .out_last       (out_s.last),
  .out_status     (out_s.status),
  .out_read_value (out_s.read_value)
);

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;

  logic clk_i;
  logic rst_ni;

  bbas_in_if  in_s ();
  bbas_out_if out_s ();
  bbas_cfg_if cfg_s ();

  i2c_bus_bridge_access_sequencer uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_s   (in_s),
    .out_s  (out_s),
    .cfg_s  (cfg_s)
  );

  typedef struct {
    logic [2:0]     cmd;
    logic [31:0]    addr;
    logic [31:0]    wv;
    logic [8:0]     cnt;
    logic [7:0]     idx;
    logic           ok;
    logic [7:0]     d;
    bit             typed;
    bbas_pkg::res_t r;
  } row_t;

  // bridge model state
  logic [6:0]  slave_q;
  logic [10:0] poll_lim_q;
  logic [3:0]  tries_q;
  logic [4:0]  ph;
  logic [2:0]  req_kind;
  logic [31:0] tgt_addr;
  logic [31:0] word_q;
  logic [1:0]  lane;
  int unsigned step_q, att_q, poll_q, burst_len, burst_pos;
  logic [7:0]  burst_mem [256];
  bit          loaded [256];

  bbas_pkg::res_t access_q [$];
  int          errs;
  bit          quiet;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // switch between stretches with and without idling
  initial begin
    quiet = 1'b0;
    forever begin
      repeat ($urandom_range(100, 400)) @(posedge clk_i);
      quiet <= ($urandom_range(0, 3) == 0);
    end
  end

  function automatic int unsigned gap_len();
    if (quiet) return 0;
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic bbas_pkg::res_t access_res();
    bbas_pkg::res_t r;
    logic [1:0] s;
    r = '0;
    r.kind = bbas_pkg::KIND_ISSUE;
    r.last = 1'b1;
    s = step_q[1:0];
    case (ph)
      bbas_pkg::PH_SEL, bbas_pkg::PH_SEL2: begin
        r.sub_address = bbas_pkg::SUB_ADDR + 6'(s);
        r.txn_data = 8'(tgt_addr >> (8 * s));
      end
      bbas_pkg::PH_WDATA: begin
        r.sub_address = bbas_pkg::SUB_WDATA + 6'(s);
        r.txn_data = 8'(word_q >> (8 * s));
      end
      bbas_pkg::PH_RDCMD: begin
        r.sub_address = bbas_pkg::SUB_CMD;
        r.txn_data = bbas_pkg::OP_READ;
      end
      bbas_pkg::PH_WRCMD: begin
        r.sub_address = bbas_pkg::SUB_CMD;
        r.txn_data = bbas_pkg::OP_WRITE;
      end
      bbas_pkg::PH_TRIG: begin
        r.sub_address = bbas_pkg::SUB_CMD;
        r.txn_data = (req_kind == bbas_pkg::CMD_BURST_RD) ? bbas_pkg::OP_BURST_RD
                                                           : bbas_pkg::OP_BURST_WR;
      end
      bbas_pkg::PH_RDPOLL, bbas_pkg::PH_WRPOLL, bbas_pkg::PH_TPOLL,
      bbas_pkg::PH_TREAD: begin
        r.txn_is_read = 1'b1;
        r.sub_address = bbas_pkg::SUB_CMD;
      end
      bbas_pkg::PH_RDATA: begin
        r.txn_is_read = 1'b1;
        r.sub_address = bbas_pkg::SUB_RDATA + 6'(s);
      end
      bbas_pkg::PH_DLEN: begin
        r.sub_address = bbas_pkg::SUB_DLEN;
        r.txn_data = 8'(burst_len - 1);
      end
      bbas_pkg::PH_RST1, bbas_pkg::PH_RST2: r.sub_address = bbas_pkg::SUB_DRST;
      bbas_pkg::PH_BRDATA: begin
        r.txn_is_read = 1'b1;
        r.sub_address = bbas_pkg::SUB_BRPORT;
      end
      bbas_pkg::PH_BWDATA: begin
        r.sub_address = bbas_pkg::SUB_BWPORT;
        r.txn_data = (burst_pos < 256) ? burst_mem[burst_pos] : 8'h00;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic bbas_pkg::res_t finish_res(logic [1:0] st);
    bbas_pkg::res_t r;
    r = '0;
    r.kind = bbas_pkg::KIND_FINISH;
    r.status = st;
    r.last = 1'b1;
    if (st == bbas_pkg::ST_OK) begin
      if (req_kind == bbas_pkg::CMD_RD_WORD) r.read_value = word_q;
      else if (req_kind == bbas_pkg::CMD_RD_BYTE)
        r.read_value = (word_q >> (8 * lane)) & 32'hFF;
    end
    if (req_kind == bbas_pkg::CMD_BURST_RD || req_kind == bbas_pkg::CMD_BURST_WR)
      r.transferred = 9'(burst_pos);
    ph = bbas_pkg::PH_IDLE;
    return r;
  endfunction

  function automatic void bridge_response(logic ok, logic [7:0] d);
    int unsigned tries, lim, sh;
    bbas_pkg::res_t r;
    tries = (tries_q < 1) ? 1 : ((tries_q > 8) ? 8 : tries_q);
    lim = (poll_lim_q < 1) ? 1 : poll_lim_q;
    if (!ok) begin
      if (att_q + 1 >= tries) access_q.push_back(finish_res(bbas_pkg::ST_FAIL));
      else begin
        att_q++;
        access_q.push_back(access_res());
      end
      return;
    end
    att_q = 0;
    case (ph)
      bbas_pkg::PH_SEL, bbas_pkg::PH_SEL2, bbas_pkg::PH_WDATA: begin
        step_q++;
        if (step_q >= 4) begin
          step_q = 0;
          if (ph == bbas_pkg::PH_WDATA) ph = bbas_pkg::PH_WRCMD;
          else if (ph == bbas_pkg::PH_SEL2 || req_kind == bbas_pkg::CMD_WR_WORD)
            ph = bbas_pkg::PH_WDATA;
          else if (req_kind >= bbas_pkg::CMD_BURST_RD) ph = bbas_pkg::PH_DLEN;
          else ph = bbas_pkg::PH_RDCMD;
        end
        access_q.push_back(access_res());
      end
      bbas_pkg::PH_RDATA: begin
        sh = 8 * step_q[1:0];
        if (!(req_kind == bbas_pkg::CMD_WR_BYTE && step_q[1:0] == lane))
          word_q = (word_q & ~(32'hFF << sh)) | (32'(d) << sh);
        step_q++;
        if (step_q < 4) access_q.push_back(access_res());
        else begin
          step_q = 0;
          if (req_kind == bbas_pkg::CMD_WR_BYTE) begin
            ph = bbas_pkg::PH_SEL2;
            access_q.push_back(access_res());
          end else access_q.push_back(finish_res(bbas_pkg::ST_OK));
        end
      end
      bbas_pkg::PH_RDCMD, bbas_pkg::PH_WRCMD, bbas_pkg::PH_TRIG: begin
        poll_q = 0;
        ph = (ph == bbas_pkg::PH_RDCMD) ? bbas_pkg::PH_RDPOLL
           : ((ph == bbas_pkg::PH_WRCMD) ? bbas_pkg::PH_WRPOLL : bbas_pkg::PH_TPOLL);
        access_q.push_back(access_res());
      end
      bbas_pkg::PH_RDPOLL, bbas_pkg::PH_WRPOLL, bbas_pkg::PH_TPOLL: begin
        if (poll_q < 2047) poll_q++;
        if (d == 8'h00) begin
          if (ph == bbas_pkg::PH_WRPOLL) access_q.push_back(finish_res(bbas_pkg::ST_OK));
          else begin
            step_q = 0;
            ph = (ph == bbas_pkg::PH_RDPOLL) ? bbas_pkg::PH_RDATA : bbas_pkg::PH_TREAD;
            access_q.push_back(access_res());
          end
        end else if (poll_q >= lim) access_q.push_back(finish_res(bbas_pkg::ST_TIMEOUT));
        else access_q.push_back(access_res());
      end
      bbas_pkg::PH_TREAD: begin
        if (req_kind == bbas_pkg::CMD_BURST_RD) begin
          ph = bbas_pkg::PH_RST2;
          access_q.push_back(access_res());
        end else access_q.push_back(finish_res(bbas_pkg::ST_OK));
      end
      bbas_pkg::PH_DLEN: begin
        ph = bbas_pkg::PH_RST1;
        access_q.push_back(access_res());
      end
      bbas_pkg::PH_RST1: begin
        ph = (req_kind == bbas_pkg::CMD_BURST_RD) ? bbas_pkg::PH_TRIG : bbas_pkg::PH_BWDATA;
        access_q.push_back(access_res());
      end
      bbas_pkg::PH_RST2: begin
        ph = (req_kind == bbas_pkg::CMD_BURST_RD) ? bbas_pkg::PH_BRDATA : bbas_pkg::PH_TRIG;
        access_q.push_back(access_res());
      end
      bbas_pkg::PH_BRDATA: begin
        burst_pos++;
        r = '0;
        r.kind = bbas_pkg::KIND_BYTE;
        r.read_value = 32'(d);
        r.transferred = 9'(burst_pos);
        access_q.push_back(r);
        if (burst_pos >= burst_len) access_q.push_back(finish_res(bbas_pkg::ST_OK));
        else access_q.push_back(access_res());
      end
      bbas_pkg::PH_BWDATA: begin
        burst_pos++;
        if (burst_pos >= burst_len) ph = bbas_pkg::PH_RST2;
        access_q.push_back(access_res());
      end
      default: ph = bbas_pkg::PH_IDLE;
    endcase
  endfunction

  function automatic void bridge_request(row_t it);
    if (it.cmd == bbas_pkg::CMD_LOAD) begin
      burst_mem[it.idx] = it.wv[7:0];
      loaded[it.idx] = 1'b1;
      return;
    end
    if (it.cmd == bbas_pkg::CMD_RESP) begin
      if (ph != bbas_pkg::PH_IDLE) bridge_response(it.ok, it.d);
      return;
    end
    if (ph != bbas_pkg::PH_IDLE) return;
    req_kind = it.cmd;
    lane = it.addr[1:0];
    tgt_addr = (it.cmd == bbas_pkg::CMD_RD_BYTE || it.cmd == bbas_pkg::CMD_WR_BYTE)
               ? {it.addr[31:2], 2'b00} : it.addr;
    if (it.cmd == bbas_pkg::CMD_WR_WORD) word_q = it.wv;
    else if (it.cmd == bbas_pkg::CMD_WR_BYTE) word_q = 32'(it.wv[7:0]) << (8 * lane);
    else word_q = '0;
    burst_len = (it.cnt < 1) ? 1 : ((it.cnt > 256) ? 256 : it.cnt);
    burst_pos = 0;
    step_q = 0;
    att_q = 0;
    poll_q = 0;
    ph = bbas_pkg::PH_SEL;
    access_q.push_back(access_res());
  endfunction

  task automatic send_request(row_t it);
    int unsigned g;
    int          before_n;
    g = gap_len();
    if (g > 0) begin
      in_s.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_s.valid        <= 1'b1;
    in_s.cmd          <= it.cmd;
    in_s.address      <= it.addr;
    in_s.write_value  <= it.wv;
    in_s.byte_count   <= it.cnt;
    in_s.buffer_index <= it.idx;
    in_s.resp_ok      <= it.ok;
    in_s.resp_data    <= it.d;
    do @(posedge clk_i); while (!in_s.ready);
    before_n = access_q.size();
    bridge_request(it);
    if (it.typed) begin
      while (access_q.size() > before_n) void'(access_q.pop_back());
      access_q.push_back(it.r);
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [10:0] val);
    cfg_s.valid <= 1'b1;
    cfg_s.index <= idx;
    cfg_s.data  <= val;
    do @(posedge clk_i); while (!cfg_s.ready);
    cfg_s.valid <= 1'b0;
    case (idx)
      bbas_pkg::REG_SLAVE:      slave_q = val[6:0];
      bbas_pkg::REG_POLL_LIMIT: poll_lim_q = val;
      bbas_pkg::REG_ATTEMPTS:   tries_q = val[3:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    in_s.valid <= 1'b0;
    while (access_q.size() > 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic int unsigned loaded_prefix();
    int unsigned n;
    n = 0;
    while (n < 256 && loaded[n]) n++;
    return n;
  endfunction

  function automatic row_t rand_item(bit allow_req);
    row_t        it;
    int unsigned pre;
    it = '{cmd: bbas_pkg::CMD_RESP, addr: $urandom, wv: $urandom, cnt: 9'($urandom),
           idx: 8'($urandom), ok: 1'b1, d: 8'($urandom), typed: 1'b0, r: '0};
    pre = loaded_prefix();
    if ($urandom_range(0, 9) == 0) begin
      it.cmd = bbas_pkg::CMD_LOAD;
      if ($urandom_range(0, 1) == 0) it.idx = 8'($urandom_range(0, (pre > 255) ? 255 : pre));
      return it;
    end
    if (ph == bbas_pkg::PH_IDLE) begin
      if (!allow_req || $urandom_range(0, 29) == 0) return it;  // response noise
      it.cmd = 3'($urandom_range(0, 5));
      if ($urandom_range(0, 39) == 0) it.cnt = ($urandom_range(0, 1) == 0) ? 9'd256
                                                : 9'($urandom_range(257, 511));
      else it.cnt = 9'($urandom_range(0, 8));
      if (it.cmd == bbas_pkg::CMD_BURST_WR && pre < 256) begin
        // only slots that were loaded get sent
        if (pre == 0) begin
          it.cmd = bbas_pkg::CMD_LOAD;
          it.idx = 8'd0;
        end else it.cnt = 9'($urandom_range(1, (pre > 8) ? 8 : pre));
      end
      return it;
    end
    if ($urandom_range(0, 24) == 0) begin
      it.cmd = 3'($urandom_range(0, 5));  // request while busy
      return it;
    end
    it.ok = ($urandom_range(0, 15) != 0);
    if (ph == bbas_pkg::PH_RDPOLL || ph == bbas_pkg::PH_WRPOLL || ph == bbas_pkg::PH_TPOLL)
      it.d = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
    return it;
  endfunction

  function automatic row_t mk_row(logic [2:0] cmd, logic [31:0] addr, logic [31:0] wv,
                                  logic [8:0] cnt, logic [7:0] idx, logic ok, logic [7:0] d);
    mk_row = '{cmd: cmd, addr: addr, wv: wv, cnt: cnt, idx: idx, ok: ok, d: d,
               typed: 1'b0, r: '0};
  endfunction

  // output side
  int unsigned stall;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_s.ready <= 1'b0;
      stall = 0;
    end else begin
      if (stall > 0) begin
        stall--;
        out_s.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        out_s.ready <= 1'b0;
      end else out_s.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    bbas_pkg::res_t got, want;
    if (rst_ni && out_s.valid && out_s.ready) begin
      got = '{kind: out_s.kind, txn_is_read: out_s.txn_is_read,
              sub_address: out_s.sub_address, txn_data: out_s.txn_data,
              read_value: out_s.read_value, status: out_s.status,
              transferred: out_s.transferred, last: out_s.last};
      if (access_q.size() == 0) begin
        errs++;
        if (errs <= 10) $display("unexpected result %p", got);
      end else begin
        want = access_q.pop_front();
        if (got !== want) begin
          errs++;
          if (errs <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    row_t        rows [$];
    row_t        it;
    logic [10:0] settings [5][3];
    int unsigned n;
    errs = 0;
    in_s.valid = 1'b0;
    in_s.cmd = bbas_pkg::CMD_RESP;
    in_s.address = '0;
    in_s.write_value = '0;
    in_s.byte_count = '0;
    in_s.buffer_index = '0;
    in_s.resp_ok = 1'b0;
    in_s.resp_data = '0;
    cfg_s.valid = 1'b0;
    cfg_s.index = bbas_pkg::REG_SLAVE;
    cfg_s.data = '0;
    slave_q = '0;
    poll_lim_q = bbas_pkg::POLL_LIMIT_RST;
    tries_q = bbas_pkg::ATTEMPTS_RST;
    ph = bbas_pkg::PH_IDLE;
    req_kind = '0;
    tgt_addr = '0;
    word_q = '0;
    lane = '0;
    step_q = 0;
    att_q = 0;
    poll_q = 0;
    burst_len = 0;
    burst_pos = 0;
    foreach (loaded[i]) begin
      loaded[i] = 1'b0;
      burst_mem[i] = 8'h00;
    end
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, registers at reset values
    rows.push_back(mk_row(bbas_pkg::CMD_RESP, '0, '0, '0, '0, 1'b1, 8'hFF));  // idle response
    rows.push_back(mk_row(bbas_pkg::CMD_LOAD, '0, 32'hFFFF_FFFF, '0, 8'd0, 1'b0, '0));
    rows.push_back(mk_row(bbas_pkg::CMD_LOAD, '0, 32'h0000_005A, '0, 8'd255, 1'b0, '0));
    rows.push_back(mk_row(bbas_pkg::CMD_LOAD, '0, 32'h1234_56A5, '0, 8'd1, 1'b0, '0));
    it = mk_row(bbas_pkg::CMD_RD_WORD, 32'hFFFF_FFFF, '0, '0, '0, 1'b0, '0);
    it.typed = 1'b1;
    it.r = '{kind: bbas_pkg::KIND_ISSUE, txn_is_read: 1'b0, sub_address: bbas_pkg::SUB_ADDR,
             txn_data: 8'hFF, read_value: '0, status: bbas_pkg::ST_OK, transferred: '0,
             last: 1'b1};
    rows.push_back(it);
    for (int c = bbas_pkg::CMD_RD_WORD; c <= bbas_pkg::CMD_BURST_WR; c++)
      rows.push_back(mk_row(3'(c), 32'h8000_0001, 32'hDEAD_BEEF, 9'd511, '0, 1'b1, '0));
    repeat (3) rows.push_back(mk_row(bbas_pkg::CMD_RESP, '0, '0, '0, '0, 1'b0, 8'h55));
    it = mk_row(bbas_pkg::CMD_RESP, '0, '0, '0, '0, 1'b0, 8'hAA);
    it.typed = 1'b1;
    it.r = '{kind: bbas_pkg::KIND_FINISH, txn_is_read: 1'b0, sub_address: '0, txn_data: '0,
             read_value: '0, status: bbas_pkg::ST_FAIL, transferred: '0, last: 1'b1};
    rows.push_back(it);
    rows.push_back(mk_row(bbas_pkg::CMD_WR_BYTE, 32'h0000_0003, 32'hFFFF_FF80, '0, '0,
                          1'b0, '0));
    repeat (4) rows.push_back(mk_row(bbas_pkg::CMD_RESP, '0, '0, '0, '0, 1'b1, 8'h00));
    foreach (rows[i]) send_request(rows[i]);

    settings[0] = '{7'd0, bbas_pkg::POLL_LIMIT_RST, bbas_pkg::ATTEMPTS_RST};
    settings[1] = '{7'd127, 11'd1, 4'd1};
    settings[2] = '{7'($urandom), 11'd2047, 4'd8};
    settings[3] = '{7'd0, 11'd0, 4'd0};
    settings[4] = '{7'($urandom), 11'd3, 4'd15};
    for (int p = 0; p < 5; p++) begin
      if (p > 0) begin
        drain();
        write_reg(bbas_pkg::REG_SLAVE, settings[p][0]);
        write_reg(bbas_pkg::REG_POLL_LIMIT, settings[p][1]);
        write_reg(bbas_pkg::REG_ATTEMPTS, settings[p][2]);
      end
      n = 0;
      while (n < 205) begin
        send_request(rand_item(1'b1));
        n++;
      end
      // let the request in progress finish before the registers change
      while (ph != bbas_pkg::PH_IDLE) send_request(rand_item(1'b0));
    end
    in_s.valid <= 1'b0;

    while (access_q.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (access_q.size() > 0) errs++;
    if (errs == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/bbas_pkg.sv
rtl/bbas_if.sv
rtl/bbas_buf.sv
rtl/bbas_outq.sv
rtl/bbas_seq.sv
rtl/i2c_bus_bridge_access_sequencer.sv
rtl/bbas_checker.sv
tb/tb.sv
